@@ src/bfba_pkg.sv @@
// Shared types, request codes and a helper function for the bitmap free-block allocator.
`timescale 1ns / 1ps

package bfba_pkg;

    // Request kinds carried on the input tuser field.
    typedef enum logic [1:0] {
        REQ_FIND = 2'd0,
        REQ_USE  = 2'd1,
        REQ_FREE = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Blocks held in one word of the free map.
    localparam int WORD_BITS = 64;
    // Width of the block number reported on the output.
    localparam int INDEX_W = 12;
    // Width of the packed tdata buses.
    localparam int TDATA_W = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic scan_step;
        logic scan_hit;
        logic mark_write;
        logic push_hit;
        logic push_miss;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic in_find;
        logic in_mark;
        logic group_nonzero;
        logic group_last;
        logic out_free;
    } status_t;

    // Position of the lowest set bit of a word; zero when the word is empty.
    function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ src/bfba_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bfba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/bfba_ctrl.sv @@
// Controller state machine that sequences clearing, finds and marks.
`timescale 1ns / 1ps

module bfba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bfba_pkg::status_t status,
    output bfba_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_FREAD  = 8'b0000_1000,
        S_FENC   = 8'b0001_0000,
        S_MREAD  = 8'b0010_0000,
        S_MWRITE = 8'b0100_0000,
        S_NOP    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the map clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.in_find) begin
                        state_next = S_SCAN;
                    end else if (status.in_mark) begin
                        state_next = S_MREAD;
                    end else begin
                        state_next = S_NOP;
                    end
                end
            end
            S_SCAN: begin
                if (status.group_nonzero) begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_FREAD;
                end else if (status.group_last) begin
                    if (status.out_free) begin
                        cmd.push_miss = 1'b1;
                        state_next    = S_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FREAD: begin
                state_next = S_FENC;
            end
            S_FENC: begin
                if (status.out_free) begin
                    cmd.push_hit = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_MREAD: begin
                state_next = S_MWRITE;
            end
            S_MWRITE: begin
                if (status.out_free) begin
                    cmd.mark_write = 1'b1;
                    cmd.push_miss  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_NOP: begin
                if (status.out_free) begin
                    cmd.push_miss = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ src/bfba_dp.sv @@
// Datapath: free map memory, per-word summary bits, scan and result registers.
`timescale 1ns / 1ps

module bfba_dp #(
    parameter int BLOCK_COUNT       = 4096,
    parameter int RESERVED_AT_START = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bfba_pkg::cmd_t                 cmd,
    output bfba_pkg::status_t              status,
    input  logic [1:0]                     s_tuser,
    input  logic [bfba_pkg::INDEX_W-1:0]   s_index,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [bfba_pkg::TDATA_W-1:0]   m_tdata,
    output logic [0:0]                     m_tuser
);

    localparam int WB   = bfba_pkg::WORD_BITS;
    localparam int NW   = (BLOCK_COUNT + WB - 1) / WB;
    localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int NG   = (NW + WB - 1) / WB;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int TAIL = BLOCK_COUNT - (NW - 1) * WB;
    // Word 0 has the reserved blocks used; the last word has no blocks past the end.
    localparam logic [WB-1:0] HEAD_MASK = ~((64'd1 << RESERVED_AT_START) - 64'd1);
    localparam logic [WB-1:0] TAIL_MASK = ~(64'hFFFF_FFFF_FFFF_FFFF << TAIL);

    logic [WAW-1:0]                 clr_cnt_reg;
    logic [WAW-1:0]                 word_addr_reg;
    logic [WAW-1:0]                 word_addr_next;
    logic [5:0]                     bit_reg;
    logic                           set_reg;
    logic [GW-1:0]                  grp_reg;
    logic [WB-1:0]                  summ_reg [NG];
    logic                           m_tvalid_reg;
    logic                           m_hit_reg;
    logic [bfba_pkg::INDEX_W-1:0]   m_index_reg;

    logic [WB-1:0]                  grp_vec;
    logic [31:0]                    scan_word32;
    logic [31:0]                    blk32;
    logic [31:0]                    blk_word32;
    logic [31:0]                    wa_grp32;
    logic [31:0]                    wa_bit32;
    logic [31:0]                    found32;
    logic                           mark_ok;
    logic                           ram_we;
    logic [WAW-1:0]                 ram_waddr;
    logic [WB-1:0]                  ram_wdata;
    logic [WB-1:0]                  ram_rdata;
    logic [WB-1:0]                  init_word;
    logic [WB-1:0]                  mod_word;
    logic                           out_free;

    // Request decode on the input side.
    assign blk32      = 32'(s_index);
    assign blk_word32 = blk32 >> 6;
    assign mark_ok    = ((s_tuser == bfba_pkg::REQ_USE) || (s_tuser == bfba_pkg::REQ_FREE))
                        && (blk32 < 32'(BLOCK_COUNT));

    // Summary group under scan and the word address of its lowest nonempty word.
    assign grp_vec     = summ_reg[grp_reg];
    assign scan_word32 = (32'(grp_reg) << 6) | 32'(bfba_pkg::lowest_set(grp_vec));
    assign wa_grp32    = 32'(word_addr_reg) >> 6;
    assign wa_bit32    = 32'(word_addr_reg) & 32'h3F;

    // Word address for the next memory access.
    always_comb begin
        word_addr_next = word_addr_reg;
        if (cmd.accept) begin
            word_addr_next = blk_word32[WAW-1:0];
        end else if (cmd.scan_hit) begin
            word_addr_next = scan_word32[WAW-1:0];
        end
    end

    // Initial contents of the word under the clearing sweep.
    always_comb begin
        init_word = '1;
        if (clr_cnt_reg == '0) begin
            init_word = init_word & HEAD_MASK;
        end
        if (clr_cnt_reg == WAW'(NW - 1)) begin
            init_word = init_word & TAIL_MASK;
        end
    end

    // Read-modify-write value for a mark request.
    always_comb begin
        mod_word          = ram_rdata;
        mod_word[bit_reg] = set_reg;
    end

    // Memory write port shared by the clearing sweep and mark writes.
    assign ram_we    = cmd.clear_step || cmd.mark_write;
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : word_addr_reg;
    assign ram_wdata = cmd.clear_step ? init_word : mod_word;

    bfba_ram #(
        .WIDTH (WB),
        .DEPTH (NW)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (word_addr_reg),
        .rdata (ram_rdata)
    );

    // Control counters and per-item registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            grp_reg     <= '0;
        end else begin
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + WAW'(1);
            end
            if (cmd.accept) begin
                grp_reg <= '0;
            end else if (cmd.scan_step) begin
                grp_reg <= grp_reg + GW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_addr_reg <= word_addr_next;
        if (cmd.accept) begin
            bit_reg <= s_index[5:0];
            set_reg <= (s_tuser == bfba_pkg::REQ_FREE);
        end
    end

    // Summary bits: one per word, set while the word holds any free block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NG; g++) begin
                for (int b = 0; b < WB; b++) begin
                    summ_reg[g][b] <= ((g * WB + b) < NW)
                                      && ((g * WB + b) * WB + WB > RESERVED_AT_START);
                end
            end
        end else if (cmd.mark_write) begin
            summ_reg[wa_grp32[GW-1:0]][wa_bit32[5:0]] <= |mod_word;
        end
    end

    // Output register; a new result loads once the previous one is taken.
    assign out_free = !m_tvalid_reg || m_tready;
    assign found32  = (32'(word_addr_reg) << 6) | 32'(bfba_pkg::lowest_set(ram_rdata));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push_hit || cmd.push_miss) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_hit) begin
            m_hit_reg   <= 1'b1;
            m_index_reg <= found32[bfba_pkg::INDEX_W-1:0];
        end else if (cmd.push_miss) begin
            m_hit_reg   <= 1'b0;
            m_index_reg <= '0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = m_hit_reg;
    assign m_tdata    = {{(bfba_pkg::TDATA_W - bfba_pkg::INDEX_W){1'b0}}, m_index_reg};

    // Status back to the controller.
    assign status.clear_last    = (clr_cnt_reg == WAW'(NW - 1));
    assign status.in_find       = (s_tuser == bfba_pkg::REQ_FIND);
    assign status.in_mark       = mark_ok;
    assign status.group_nonzero = |grp_vec;
    assign status.group_last    = (grp_reg == GW'(NG - 1));
    assign status.out_free      = out_free;

endmodule

@@ src/bitmap_free_block_allocator.sv @@
// Top level of the bitmap free-block allocator: controller plus datapath.
// Find scans the 64-word summary groups in order (1 group at 4096 blocks), then reads and encodes the chosen word.
// Mark-used and mark-free read the word, then write it back; other codes return a miss result directly.
// The result sits in an output register; the next item is taken once the current one ends.
// After reset a sweep writes all ceil(BLOCK_COUNT / 64) words of the free map (64 at 4096 blocks),
// one 64-block word per cycle, with s_tready low meanwhile.
`timescale 1ns / 1ps

module bitmap_free_block_allocator #(
    parameter int BLOCK_COUNT       = 4096,
    parameter int RESERVED_AT_START = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] block_index, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] free_block_index, [15:12] zero
    output logic [0:0]  m_tuser    // [0] search_hit
);

    bfba_pkg::cmd_t    cmd;
    bfba_pkg::status_t status;

    bfba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bfba_dp #(
        .BLOCK_COUNT       (BLOCK_COUNT),
        .RESERVED_AT_START (RESERVED_AT_START)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_index  (s_tdata[bfba_pkg::INDEX_W-1:0]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the bitmap free-block allocator.
`timescale 1ns / 1ps

module tb;

    localparam int BLOCKS        = 4096;
    localparam int RESERVED      = 10;
    localparam int RANDOM_ITEMS  = 390;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 1000;

    // One request item and the result that it is expected to produce.
    typedef struct packed {
        bfba_pkg::req_t kind;
        logic [11:0]    blk;
    } block_request_t;

    typedef struct packed {
        logic        hit;
        logic [11:0] index;
    } alloc_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [11:0] block_index, [15:12] zero
    logic [1:0]  s_tuser  = bfba_pkg::REQ_NONE;  // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [11:0] free_block_index, [15:12] zero
    logic [0:0]  m_tuser;          // [0] search_hit

    // Pending requests, expected allocator answers, and the two free maps:
    // one follows the accepted items, the other follows the plan as it is built.
    block_request_t    request_q[$];
    alloc_result_t     answer_q[$];
    logic [BLOCKS-1:0] block_free;
    logic [BLOCKS-1:0] plan_free;

    int unsigned send_wait    = 0;
    int unsigned recv_wait    = 0;
    int unsigned requests_in  = 0;
    int unsigned answers_out  = 0;
    int unsigned hits_seen    = 0;
    int unsigned finds_in     = 0;
    int unsigned error_count  = 0;
    int unsigned idle_cycles  = 0;

    bitmap_free_block_allocator #(
        .BLOCK_COUNT      (BLOCKS),
        .RESERVED_AT_START(RESERVED)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Apply one request to a free map and return the allocator's answer.
    function automatic alloc_result_t serve_request(inout logic [BLOCKS-1:0] map,
                                                    input bfba_pkg::req_t kind,
                                                    input logic [11:0] blk);
        alloc_result_t res;
        res = '0;
        case (kind)
            bfba_pkg::REQ_FIND: begin
                // Walk downward so the last hit kept is the lowest free block.
                for (int i = BLOCKS - 1; i >= 0; i--) begin
                    if (map[i]) begin
                        res.hit   = 1'b1;
                        res.index = 12'(i);
                    end
                end
            end
            bfba_pkg::REQ_USE:  map[blk] = 1'b0;
            bfba_pkg::REQ_FREE: map[blk] = 1'b1;
            default: ;
        endcase
        return res;
    endfunction

    // Gap length: mostly short, a few long, and calm stretches with none.
    function automatic int unsigned pick_gap(input int unsigned n);
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((n % 80) < 20 || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Block number biased toward the low region where finds see the effect.
    function automatic logic [11:0] pick_block();
        if ($urandom_range(0, 99) < 70) begin
            return 12'($urandom_range(0, 511));
        end
        return 12'($urandom_range(0, BLOCKS - 1));
    endfunction

    // Add one request to the plan and tell what it will answer.
    task automatic plan_request(input bfba_pkg::req_t kind, input logic [11:0] blk,
                                output alloc_result_t res);
        request_q.push_back('{kind: kind, blk: blk});
        res = serve_request(plan_free, kind, blk);
    endtask

    // Driver: present queued items, predict each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                answer_q.push_back(serve_request(block_free, bfba_pkg::req_t'(s_tuser),
                                                 s_tdata[11:0]));
                requests_in++;
                if (bfba_pkg::req_t'(s_tuser) == bfba_pkg::REQ_FIND) begin
                    finds_in++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end else if (request_q.size() != 0) begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {4'b0000, request_q[0].blk};
                    s_tuser   <= request_q[0].kind;
                    send_wait <= pick_gap(requests_in);
                    void'(request_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expected answer.
    always @(posedge aclk) begin
        int unsigned stall;
        alloc_result_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            answers_out++;
            if (answer_q.size() == 0) begin
                $error("result item with no request outstanding: hit %0d index %0d",
                       m_tuser[0], m_tdata[11:0]);
                error_count++;
            end else begin
                want = answer_q.pop_front();
                if (m_tuser[0] !== want.hit) begin
                    $error("search_hit: expected %0d, actual %0d", want.hit, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[11:0] !== want.index) begin
                    $error("free_block_index: expected %0d, actual %0d",
                           want.index, m_tdata[11:0]);
                    error_count++;
                end
                if (want.hit) begin
                    hits_seen++;
                end
            end
            if (m_tdata[15:12] !== 4'b0000) begin
                $error("tdata padding: expected 0, actual %0h", m_tdata[15:12]);
                error_count++;
            end
            stall     = pick_gap(answers_out);
            m_tready  <= (stall == 0);
            recv_wait <= (stall == 0) ? 0 : stall - 1;
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin
        alloc_result_t res;
        int unsigned   counted;
        int unsigned   r;
        int unsigned   start;
        int unsigned   run;
        int unsigned   total;

        for (int i = 0; i < BLOCKS; i++) begin
            block_free[i] = (i >= RESERVED);
        end
        plan_free = block_free;

        // Directed: reset state, reserved edge, extremes and the unused code.
        plan_request(bfba_pkg::REQ_FIND, 12'd0, res);
        plan_request(bfba_pkg::REQ_FREE, 12'd9, res);
        plan_request(bfba_pkg::REQ_FIND, 12'hFFF, res);
        plan_request(bfba_pkg::REQ_USE, 12'd9, res);
        plan_request(bfba_pkg::REQ_USE, 12'd10, res);
        plan_request(bfba_pkg::REQ_FIND, 12'd0, res);
        plan_request(bfba_pkg::REQ_FREE, 12'd0, res);
        plan_request(bfba_pkg::REQ_FIND, 12'd0, res);
        plan_request(bfba_pkg::REQ_FREE, 12'd0, res);
        plan_request(bfba_pkg::REQ_USE, 12'd0, res);
        plan_request(bfba_pkg::REQ_USE, 12'd0, res);
        plan_request(bfba_pkg::REQ_NONE, 12'hFFF, res);
        plan_request(bfba_pkg::REQ_NONE, 12'd0, res);
        plan_request(bfba_pkg::REQ_FIND, 12'd0, res);
        plan_request(bfba_pkg::REQ_USE, 12'hFFF, res);
        plan_request(bfba_pkg::REQ_FREE, 12'hFFF, res);
        plan_request(bfba_pkg::REQ_FREE, 12'h555, res);
        plan_request(bfba_pkg::REQ_USE, 12'hAAA, res);

        // Use up the first two words so that a find has to look past them,
        // then free a few blocks around word edges and at the top of the map.
        for (int i = 0; i < 128; i++) begin
            plan_request(bfba_pkg::REQ_USE, 12'(i), res);
        end
        plan_request(bfba_pkg::REQ_FIND, 12'd0, res);
        plan_request(bfba_pkg::REQ_NONE, 12'h800, res);
        plan_request(bfba_pkg::REQ_FREE, 12'hFFF, res);
        plan_request(bfba_pkg::REQ_FIND, 12'd0, res);
        plan_request(bfba_pkg::REQ_FREE, 12'd64, res);
        plan_request(bfba_pkg::REQ_FIND, 12'd0, res);
        plan_request(bfba_pkg::REQ_FREE, 12'd63, res);
        plan_request(bfba_pkg::REQ_FIND, 12'd0, res);

        // Random traffic, mostly allocate-then-claim pairs and releases.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                plan_request(bfba_pkg::REQ_FIND, 12'($urandom), res);
                plan_request(bfba_pkg::REQ_USE, res.hit ? res.index : pick_block(), res);
                counted += 2;
            end else if (r < 65) begin
                plan_request(bfba_pkg::REQ_FREE, pick_block(), res);
                counted++;
                if ($urandom_range(0, 1) == 1) begin
                    plan_request(bfba_pkg::REQ_FIND, 12'($urandom), res);
                    counted++;
                end
            end else if (r < 85) begin
                plan_request(bfba_pkg::REQ_USE, pick_block(), res);
                counted++;
            end else if (r < 92) begin
                plan_request(bfba_pkg::REQ_FIND, 12'($urandom), res);
                counted++;
            end else if (r < 97) begin
                plan_request(bfba_pkg::REQ_NONE, 12'($urandom), res);
            end else begin
                // Claim a run of blocks that may cross a word edge.
                start = $urandom_range(0, 400);
                run   = $urandom_range(10, 80);
                for (int unsigned i = 0; i < run; i++) begin
                    plan_request(bfba_pkg::REQ_USE, 12'(start + i), res);
                end
                plan_request(bfba_pkg::REQ_FIND, 12'd0, res);
                counted += run + 1;
            end
        end
        total = request_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (answers_out < total) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results for %0d requests, including %0d finds.",
                 answers_out, requests_in, finds_in);
        $display("Finds reported %0d hits and %0d misses; %0d mismatches.",
                 hits_seen, finds_in - hits_seen, error_count);
        if (error_count == 0 && answer_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
